/* hdl/gsig_pkg.sv */
`default_nettype none

package gsig_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GUIDE_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_COS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_SIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL = 3'd5;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_GUIDE = 2'd1;
    localparam logic [1:0] REQ_PIXEL = 2'd2;

    // Ratio of neighbouring table entries, exp(-1/160) in 0.32 fixed point.
    localparam logic [31:0] EXP_FACTOR = 32'd4268207462;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_GUIDE = 2'd1,
        OP_PIXEL = 2'd2,
        OP_BLANK = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] ra_plus_ticks;
        logic [15:0] ra_minus_ticks;
        logic [15:0] dec_plus_ticks;
        logic [15:0] dec_minus_ticks;
        logic [9:0]  pixel_col;
        logic [8:0]  pixel_row;
    } t_req;

    typedef struct packed {
        logic [15:0]        pixel_value;
        logic               ra_moving;
        logic               dec_moving;
        logic signed [15:0] star_col;
        logic signed [15:0] star_row;
    } t_res;

    typedef struct packed {
        t_op         op;
        logic [15:0] ra_cnt;
        logic        ra_neg;
        logic [15:0] dec_cnt;
        logic        dec_neg;
        logic [9:0]  col;
        logic [8:0]  row;
    } t_cmd;

    typedef struct packed {
        logic signed [23:0] drift_rate_x;
        logic signed [23:0] drift_rate_y;
        logic [23:0]        guide_rate;
        logic signed [15:0] axis_cos;
        logic signed [15:0] axis_sin;
        logic [15:0]        peak_level;
    } t_cfg;

endpackage

`default_nettype wire

/* hdl/guided_star_image_generator.sv */
// Synthetic guide-star camera. Request words enter through a push/full queue
// port and every request gives exactly one result word on the empty/pop side,
// in order. After reset the block fills its exp(-r^2/5) table and holds full
// high meanwhile; configuration writes are taken at any time but should only
// be made while the block is idle. A guide command or an ignored request is
// finished in the execution unit's idle state, a time tick goes through a
// guide-step multiply, then a saturating position update, and a pixel request
// through offset, two squaring steps, table read and scaling by the peak
// level. The execution sequencer, with its single squaring multiplier, works
// on one request at a time. Two-word queues sit before and after the
// execution unit.
`default_nettype none

module guided_star_image_generator #(
    parameter int FRAME_WIDTH     = 640,
    parameter int FRAME_HEIGHT    = 480,
    parameter int EXP_TABLE_DEPTH = 2048
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire gsig_pkg::t_req                     i_req_word,
    output logic                                    empty,
    input  wire logic                               pop,
    output gsig_pkg::t_res                          o_res_word,
    input  wire logic                               i_cfg_wen,
    input  wire logic [gsig_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [gsig_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    import gsig_pkg::*;

    t_cfg r_cfg;
    logic cmd_push;
    t_cmd cmd_in;
    t_cmd cmd_out;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;
    logic back_ready;
    logic res_push;
    logic res_full;
    t_res res_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drift_rate_x <= 24'sd1678;
            r_cfg.drift_rate_y <= 24'sd3355;
            r_cfg.guide_rate   <= 24'd167772;
            r_cfg.axis_cos     <= 16'sd17705;
            r_cfg.axis_sin     <= 16'sd27574;
            r_cfg.peak_level   <= 16'd10000;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_DRIFT_X: begin
                    r_cfg.drift_rate_x <= i_cfg_wdata;
                end
                CFG_DRIFT_Y: begin
                    r_cfg.drift_rate_y <= i_cfg_wdata;
                end
                CFG_GUIDE_RATE: begin
                    r_cfg.guide_rate <= i_cfg_wdata;
                end
                CFG_AXIS_COS: begin
                    r_cfg.axis_cos <= i_cfg_wdata[15:0];
                end
                CFG_AXIS_SIN: begin
                    r_cfg.axis_sin <= i_cfg_wdata[15:0];
                end
                CFG_PEAK_LEVEL: begin
                    r_cfg.peak_level <= i_cfg_wdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    gsig_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .i_push   (push),
        .i_req    (i_req_word),
        .i_q_full (cmd_full),
        .i_ready  (back_ready),
        .o_full   (full),
        .o_push   (cmd_push),
        .o_cmd    (cmd_in)
    );

    gsig_queue #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .o_empty (cmd_empty),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out)
    );

    gsig_back #(
        .FRAME_WIDTH     (FRAME_WIDTH),
        .FRAME_HEIGHT    (FRAME_HEIGHT),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .o_ready     (back_ready)
    );

    gsig_queue #(
        .WIDTH ($bits(t_res)),
        .DEPTH (2)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_res_word)
    );

endmodule

`default_nettype wire

/* hdl/gsig_queue.sv */
`default_nettype none

module gsig_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_store [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_store[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/gsig_front.sv */
`default_nettype none

module gsig_front #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  wire logic          i_push,
    input  wire gsig_pkg::t_req i_req,
    input  wire logic          i_q_full,
    input  wire logic          i_ready,
    output logic               o_full,
    output logic               o_push,
    output gsig_pkg::t_cmd     o_cmd
);

    import gsig_pkg::*;

    logic in_frame;

    assign o_full   = i_q_full || !i_ready;
    assign o_push   = i_push && !o_full;
    assign in_frame = (32'(i_req.pixel_col) < 32'(FRAME_WIDTH)) &&
                      (32'(i_req.pixel_row) < 32'(FRAME_HEIGHT));

    always_comb begin
        o_cmd     = '0;
        o_cmd.col = i_req.pixel_col;
        o_cmd.row = i_req.pixel_row;

        // A plus pulse takes precedence over a minus pulse on each axis.
        if (i_req.ra_plus_ticks != '0) begin
            o_cmd.ra_cnt = i_req.ra_plus_ticks;
        end else if (i_req.ra_minus_ticks != '0) begin
            o_cmd.ra_cnt = i_req.ra_minus_ticks;
            o_cmd.ra_neg = 1'b1;
        end
        if (i_req.dec_plus_ticks != '0) begin
            o_cmd.dec_cnt = i_req.dec_plus_ticks;
        end else if (i_req.dec_minus_ticks != '0) begin
            o_cmd.dec_cnt = i_req.dec_minus_ticks;
            o_cmd.dec_neg = 1'b1;
        end

        unique case (i_req.req_type)
            REQ_TICK: begin
                o_cmd.op = OP_TICK;
            end
            REQ_GUIDE: begin
                o_cmd.op = OP_GUIDE;
            end
            REQ_PIXEL: begin
                o_cmd.op = in_frame ? OP_PIXEL : OP_BLANK;
            end
            default: begin
                o_cmd.op = OP_BLANK;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/gsig_back.sv */
`default_nettype none

module gsig_back #(
    parameter int FRAME_WIDTH     = 640,
    parameter int FRAME_HEIGHT    = 480,
    parameter int EXP_TABLE_DEPTH = 2048
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire gsig_pkg::t_cfg i_cfg,
    input  wire logic           i_cmd_valid,
    input  wire gsig_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    input  wire logic           i_res_full,
    output logic                o_res_push,
    output gsig_pkg::t_res      o_res,
    output logic                o_ready
);

    import gsig_pkg::*;

    localparam int AW = $clog2(EXP_TABLE_DEPTH);
    localparam logic signed [39:0] POS_X_RST = 40'(FRAME_WIDTH / 2) <<< 24;
    localparam logic signed [39:0] POS_Y_RST = 40'(FRAME_HEIGHT / 2) <<< 24;
    localparam logic signed [41:0] NEAR_LIM  = 42'sh0_4000_0000;

    typedef enum logic [8:0] {
        S_FILL  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_TMUL  = 9'b000000100,
        S_TSUM  = 9'b000001000,
        S_PDIFF = 9'b000010000,
        S_PSQX  = 9'b000100000,
        S_PSQY  = 9'b001000000,
        S_PADDR = 9'b010000000,
        S_PMUL  = 9'b100000000
    } t_state;

    function automatic logic signed [39:0] sat_pos(input logic signed [41:0] v);
        logic signed [39:0] res;
        if (v[41:39] == 3'b000 || v[41:39] == 3'b111) begin
            res = v[39:0];
        end else if (v[41]) begin
            res = {1'b1, 39'd0};
        end else begin
            res = {1'b0, {39{1'b1}}};
        end
        return res;
    endfunction

    t_state             r_state, n_state;
    logic [AW-1:0]      r_fill_k;
    logic [31:0]        r_e;
    logic signed [39:0] r_pos_x, n_pos_x;
    logic signed [39:0] r_pos_y, n_pos_y;
    logic [15:0]        r_ra_rem, n_ra_rem;
    logic               r_ra_neg, n_ra_neg;
    logic [15:0]        r_dec_rem, n_dec_rem;
    logic               r_dec_neg, n_dec_neg;
    t_cmd               r_cmd;
    logic signed [25:0] r_ux, r_uy;
    logic signed [30:0] r_dx, r_dy;
    logic               r_near;
    logic [59:0]        r_sqx, r_sqy;
    logic               r_hit, r_idx0;
    logic [15:0]        r_rom_q;
    logic [15:0]        r_mem [EXP_TABLE_DEPTH];

    logic [63:0]        e_prod;
    logic signed [40:0] prod_ux, prod_uy;
    logic signed [41:0] ux_ext, uy_ext;
    logic signed [41:0] ra_dx, ra_dy, dec_dx, dec_dy;
    logic signed [41:0] sum_x, sum_y;
    logic signed [41:0] dx, dy;
    logic signed [61:0] sq_full;
    logic [60:0]        r2;
    logic [17:0]        idx;
    logic [31:0]        pk_prod;
    logic [15:0]        res_pix;

    // Table fill: e(k+1) = round(e(k) * factor), entry k holds the top half of e(k).
    assign e_prod  = 64'(r_e) * 64'(EXP_FACTOR) + 64'h0000_0000_8000_0000;

    assign prod_ux = $signed({1'b0, i_cfg.guide_rate}) * i_cfg.axis_cos;
    assign prod_uy = $signed({1'b0, i_cfg.guide_rate}) * i_cfg.axis_sin;

    assign ux_ext  = 42'(r_ux);
    assign uy_ext  = 42'(r_uy);
    assign ra_dx   = (r_ra_rem == '0) ? '0 : (r_ra_neg ? -ux_ext : ux_ext);
    assign ra_dy   = (r_ra_rem == '0) ? '0 : (r_ra_neg ? -uy_ext : uy_ext);
    assign dec_dx  = (r_dec_rem == '0) ? '0 : (r_dec_neg ? uy_ext : -uy_ext);
    assign dec_dy  = (r_dec_rem == '0) ? '0 : (r_dec_neg ? -ux_ext : ux_ext);
    assign sum_x   = 42'(r_pos_x) + 42'(i_cfg.drift_rate_x) + ra_dx + dec_dx;
    assign sum_y   = 42'(r_pos_y) + 42'(i_cfg.drift_rate_y) + ra_dy + dec_dy;

    assign dx      = $signed({8'd0, r_cmd.col, 24'd0}) - 42'(r_pos_x);
    assign dy      = $signed({9'd0, r_cmd.row, 24'd0}) - 42'(r_pos_y);
    assign sq_full = r_state == S_PSQX ? r_dx * r_dx : r_dy * r_dy;
    assign r2      = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign idx     = r2[60:43];

    assign pk_prod = 32'(i_cfg.peak_level) * 32'(r_rom_q);
    assign o_ready = (r_state != S_FILL);

    always_comb begin
        n_state    = r_state;
        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        n_ra_rem   = r_ra_rem;
        n_ra_neg   = r_ra_neg;
        n_dec_rem  = r_dec_rem;
        n_dec_neg  = r_dec_neg;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        res_pix    = '0;

        unique case (r_state)
            S_FILL: begin
                if (r_fill_k == AW'(EXP_TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_TICK: begin
                            n_state = S_TMUL;
                        end
                        OP_PIXEL: begin
                            n_state = S_PDIFF;
                        end
                        OP_GUIDE: begin
                            n_ra_rem   = i_cmd.ra_cnt;
                            n_ra_neg   = i_cmd.ra_neg;
                            n_dec_rem  = i_cmd.dec_cnt;
                            n_dec_neg  = i_cmd.dec_neg;
                            o_res_push = 1'b1;
                        end
                        default: begin
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_TMUL: begin
                n_state = S_TSUM;
            end
            S_TSUM: begin
                n_pos_x    = sat_pos(sum_x);
                n_pos_y    = sat_pos(sum_y);
                n_ra_rem   = r_ra_rem - 16'(r_ra_rem != '0);
                n_dec_rem  = r_dec_rem - 16'(r_dec_rem != '0);
                o_res_push = 1'b1;
                n_state    = S_IDLE;
            end
            S_PDIFF: begin
                n_state = S_PSQX;
            end
            S_PSQX: begin
                n_state = S_PSQY;
            end
            S_PSQY: begin
                n_state = S_PADDR;
            end
            S_PADDR: begin
                n_state = S_PMUL;
            end
            S_PMUL: begin
                if (!r_hit) begin
                    res_pix = '0;
                end else if (r_idx0) begin
                    res_pix = i_cfg.peak_level;
                end else begin
                    res_pix = pk_prod[31:16];
                end
                o_res_push = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.pixel_value = res_pix;
    assign o_res.ra_moving   = (n_ra_rem != '0);
    assign o_res.dec_moving  = (n_dec_rem != '0);
    assign o_res.star_col    = n_pos_x[39:24];
    assign o_res.star_row    = n_pos_y[39:24];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_fill_k  <= '0;
            r_pos_x   <= POS_X_RST;
            r_pos_y   <= POS_Y_RST;
            r_ra_rem  <= '0;
            r_ra_neg  <= 1'b0;
            r_dec_rem <= '0;
            r_dec_neg <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_ra_rem  <= n_ra_rem;
            r_ra_neg  <= n_ra_neg;
            r_dec_rem <= n_dec_rem;
            r_dec_neg <= n_dec_neg;
            if (r_state == S_FILL) begin
                r_fill_k <= r_fill_k + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FILL) begin
            r_e <= (r_fill_k == '0) ? EXP_FACTOR : e_prod[63:32];
        end
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_TMUL) begin
            r_ux <= prod_ux[40:15];
            r_uy <= prod_uy[40:15];
        end
        if (r_state == S_PDIFF) begin
            r_dx   <= dx[30:0];
            r_dy   <= dy[30:0];
            r_near <= (dx < NEAR_LIM) && (dx > -NEAR_LIM) &&
                      (dy < NEAR_LIM) && (dy > -NEAR_LIM);
        end
        if (r_state == S_PSQX) begin
            r_sqx <= sq_full[59:0];
        end
        if (r_state == S_PSQY) begin
            r_sqy <= sq_full[59:0];
        end
        if (r_state == S_PADDR) begin
            r_hit  <= r_near && (idx < 18'(EXP_TABLE_DEPTH));
            r_idx0 <= (idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FILL) begin
            r_mem[r_fill_k] <= r_e[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rom_q <= r_mem[idx[AW-1:0]];
    end

    a_no_pop_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> !o_cmd_pop)
        else $error("command taken while the table is being filled");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    a_short_ops_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && (i_cmd.op == OP_GUIDE || i_cmd.op == OP_BLANK)) |-> o_res_push)
        else $error("guide or blank command did not complete at once");

    a_ra_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TSUM && r_ra_rem != '0) |=> (r_ra_rem == $past(r_ra_rem) - 16'd1))
        else $error("RA pulse count did not step down on a tick");

endmodule

`default_nettype wire

/* tb/tb_guided_star_image_generator.sv */
`timescale 1ns / 100ps

module tb_guided_star_image_generator;

    import gsig_pkg::*;

    localparam int FRAME_W     = 640;
    localparam int FRAME_H     = 480;
    localparam int EXP_DEPTH   = 2048;
    localparam int HOLD_CYCLES = 300;
    localparam int END_CYCLES  = 50;
    localparam int LIMIT       = 1500000;

    localparam logic signed [39:0] POS_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] POS_MIN = 40'sh80_0000_0000;
    localparam longint FAR_LIM = 64'sd1073741824;
    localparam logic [63:0] EXP_RATIO = 64'd4268207462;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    t_req        i_req_word = '0;
    logic        pop = 1'b0;
    logic        i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic        full;
    logic        empty;
    t_res        o_res_word;

    // Predicted camera state and register copy.
    logic signed [39:0] star_x;
    logic signed [39:0] star_y;
    logic [15:0]        ra_left;
    logic [15:0]        dec_left;
    logic               ra_neg;
    logic               dec_neg;
    t_cfg               cam_cfg;
    logic [16:0]        exp_table [EXP_DEPTH];

    t_res pending_words [$];
    int   bad_words = 0;
    int   cycle_count = 0;
    bit   quiet = 1'b0;
    bit   hold_toggle = 1'b0;
    bit   hold_seen = 1'b0;
    int   hold_left = 0;
    int   gap_left = 0;

    guided_star_image_generator #(
        .FRAME_WIDTH     (FRAME_W),
        .FRAME_HEIGHT    (FRAME_H),
        .EXP_TABLE_DEPTH (EXP_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req_word  (i_req_word),
        .empty       (empty),
        .pop         (pop),
        .o_res_word  (o_res_word),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic signed [39:0] clamp_pos(longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v[39:0];
    endfunction

    function automatic logic [16:0] pulse_load(logic [15:0] plus_len, logic [15:0] minus_len);
        if (plus_len != 0) return {plus_len, 1'b0};
        if (minus_len != 0) return {minus_len, 1'b1};
        return '0;
    endfunction

    function automatic t_res camera_step(t_req r);
        t_res   w;
        longint g, c, s, ux, uy, nx, ny, dx, dy, r2, idx;
        w = '0;
        case (t_op'(r.req_type))
            OP_TICK: begin
                g  = longint'(cam_cfg.guide_rate);
                c  = $signed(cam_cfg.axis_cos);
                s  = $signed(cam_cfg.axis_sin);
                ux = (g * c) >>> 15;
                uy = (g * s) >>> 15;
                nx = star_x + $signed(cam_cfg.drift_rate_x);
                ny = star_y + $signed(cam_cfg.drift_rate_y);
                if (ra_left != 0) begin
                    nx = ra_neg ? nx - ux : nx + ux;
                    ny = ra_neg ? ny - uy : ny + uy;
                    ra_left = ra_left - 1'b1;
                end
                if (dec_left != 0) begin
                    nx = dec_neg ? nx + uy : nx - uy;
                    ny = dec_neg ? ny - ux : ny + ux;
                    dec_left = dec_left - 1'b1;
                end
                star_x = clamp_pos(nx);
                star_y = clamp_pos(ny);
            end
            OP_GUIDE: begin
                {ra_left, ra_neg}   = pulse_load(r.ra_plus_ticks, r.ra_minus_ticks);
                {dec_left, dec_neg} = pulse_load(r.dec_plus_ticks, r.dec_minus_ticks);
            end
            OP_PIXEL: begin
                if (r.pixel_col < FRAME_W && r.pixel_row < FRAME_H) begin
                    dx = (longint'(r.pixel_col) << 24) - star_x;
                    dy = (longint'(r.pixel_row) << 24) - star_y;
                    if (dx < FAR_LIM && dx > -FAR_LIM && dy < FAR_LIM && dy > -FAR_LIM) begin
                        r2  = dx * dx + dy * dy;
                        idx = r2 >>> 43;
                        if (idx < EXP_DEPTH) begin
                            w.pixel_value = 16'((longint'(cam_cfg.peak_level)
                                                 * exp_table[idx]) >>> 16);
                        end
                    end
                end
            end
            default: ;
        endcase
        w.ra_moving  = (ra_left != 0);
        w.dec_moving = (dec_left != 0);
        w.star_col   = star_x[39:24];
        w.star_row   = star_y[39:24];
        return w;
    endfunction

    function automatic t_req base_req(t_op op);
        logic [95:0] bits;
        t_req        r;
        bits = {$urandom, $urandom, $urandom};
        r = bits[$bits(t_req)-1:0];
        r.req_type = op;
        return r;
    endfunction

    function automatic t_req guide_req(logic [15:0] rp, logic [15:0] rm,
                                       logic [15:0] dp, logic [15:0] dm);
        t_req r;
        r = base_req(OP_GUIDE);
        r.ra_plus_ticks   = rp;
        r.ra_minus_ticks  = rm;
        r.dec_plus_ticks  = dp;
        r.dec_minus_ticks = dm;
        return r;
    endfunction

    function automatic t_req pixel_req(logic [9:0] col, logic [8:0] row);
        t_req r;
        r = base_req(OP_PIXEL);
        r.pixel_col = col;
        r.pixel_row = row;
        return r;
    endfunction

    function automatic logic [31:0] pulse_pair();
        logic [15:0] len;
        len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 40)) : 16'($urandom);
        case ($urandom_range(0, 3))
            0, 1:    return {len, 16'($urandom)};
            2:       return {16'd0, len};
            default: return 32'd0;
        endcase
    endfunction

    function automatic t_req random_req();
        int     sel;
        longint pc, pr;
        t_req   r;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            r = base_req(OP_TICK);
        end else if (sel < 55) begin
            r = base_req(OP_GUIDE);
            {r.ra_plus_ticks, r.ra_minus_ticks}   = pulse_pair();
            {r.dec_plus_ticks, r.dec_minus_ticks} = pulse_pair();
        end else if (sel < 95) begin
            r = base_req(OP_PIXEL);
            if ($urandom_range(0, 9) < 7) begin
                pc = (star_x >>> 24) + longint'($urandom_range(0, 18)) - 9;
                pr = (star_y >>> 24) + longint'($urandom_range(0, 18)) - 9;
                pc = (pc < 0) ? 0 : ((pc > 1023) ? 1023 : pc);
                pr = (pr < 0) ? 0 : ((pr > 511) ? 511 : pr);
                r.pixel_col = pc[9:0];
                r.pixel_row = pr[8:0];
            end
        end else begin
            r = base_req(OP_BLANK);
        end
        return r;
    endfunction

    task automatic send_req(t_req r);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_req_word <= r;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pending_words.insert(pending_words.size(), camera_step(r));
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_DRIFT_X:    cam_cfg.drift_rate_x = data;
            CFG_DRIFT_Y:    cam_cfg.drift_rate_y = data;
            CFG_GUIDE_RATE: cam_cfg.guide_rate   = data;
            CFG_AXIS_COS:   cam_cfg.axis_cos     = data[15:0];
            CFG_AXIS_SIN:   cam_cfg.axis_sin     = data[15:0];
            CFG_PEAK_LEVEL: cam_cfg.peak_level   = data[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [23:0] drx, logic [23:0] dry, logic [23:0] rate,
                                 logic [15:0] cs, logic [15:0] sn, logic [15:0] pk);
        drain_results();
        set_reg(CFG_DRIFT_X, drx);
        set_reg(CFG_DRIFT_Y, dry);
        set_reg(CFG_GUIDE_RATE, rate);
        set_reg(CFG_AXIS_COS, {8'($urandom), cs});
        set_reg(CFG_AXIS_SIN, {8'($urandom), sn});
        set_reg(CFG_PEAK_LEVEL, {8'($urandom), pk});
        i_cfg_wen <= 1'b0;
    endtask

    task automatic run_random(int count);
        repeat (count) send_req(random_req());
    endtask

    task automatic test_reset_values();
        send_req(pixel_req(10'd320, 9'd240));
        send_req(pixel_req(10'd327, 9'd240));
        send_req(pixel_req(10'd328, 9'd240));
        send_req(pixel_req(10'd384, 9'd240));
        send_req(pixel_req(10'd256, 9'd300));
        send_req(pixel_req(10'd640, 9'd240));
        send_req(pixel_req(10'd0, 9'd480));
        send_req(pixel_req(10'd1023, 9'd511));
        send_req(pixel_req(10'd0, 9'd0));
        send_req(base_req(OP_BLANK));
        send_req(guide_req(16'd5, 16'hFFFF, 16'd7, 16'd9));
        send_req(base_req(OP_TICK));
        send_req(base_req(OP_TICK));
        send_req(guide_req(16'd0, 16'd3, 16'd0, 16'hFFFF));
        repeat (3) send_req(base_req(OP_TICK));
        send_req(guide_req(16'd0, 16'd0, 16'd0, 16'd0));
        send_req(base_req(OP_TICK));
        send_req(guide_req(16'hFFFF, 16'd0, 16'd0, 16'd2));
        send_req(base_req(OP_TICK));
        send_req(pixel_req(10'd320, 9'd240));
        send_req(guide_req(16'd1, 16'd0, 16'd1, 16'd0));
        send_req(base_req(OP_TICK));
        send_req(base_req(OP_TICK));
    endtask

    task automatic test_register_settings();
        apply_setting(24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        run_random(100);
        apply_setting(24'h800000, 24'h800000, 24'h000000, 16'h8000, 16'h8000, 16'h0000);
        run_random(100);
        apply_setting(24'($urandom_range(0, 8000)) - 24'd4000,
                      24'($urandom_range(0, 8000)) - 24'd4000,
                      24'($urandom_range(0, 4194304)), 16'($urandom), 16'($urandom),
                      16'($urandom));
        run_random(100);
        apply_setting(24'd1678, 24'd3355, 24'd167772, 16'd17705, 16'd27574, 16'($urandom));
        run_random(100);
    endtask

    task automatic test_backpressure();
        apply_setting(24'($urandom_range(0, 8000)) - 24'd4000,
                      24'($urandom_range(0, 8000)) - 24'd4000,
                      24'($urandom_range(0, 1048576)), 16'($urandom), 16'($urandom),
                      16'($urandom_range(1000, 65535)));
        hold_toggle = ~hold_toggle;
        run_random(60);
    endtask

    task automatic test_quiet_stream();
        quiet = 1'b1;
        apply_setting(24'd1000, 24'hFFFC18, 24'd300000, 16'h7FFF, 16'h0000, 16'hFFFF);
        run_random(60);
    endtask

    // Push the star hard along a skewed axis with a long RA pulse at the largest rates.
    task automatic test_position_limits();
        apply_setting(24'h7FFFFF, 24'h800000, 24'hFFFFFF, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_req(guide_req(16'hFFFF, 16'd0, 16'd0, 16'd0));
        repeat (30) send_req(base_req(OP_TICK));
        send_req(pixel_req(10'd639, 9'd0));
        send_req(guide_req(16'd0, 16'd0, 16'd0, 16'd4));
        repeat (5) send_req(base_req(OP_TICK));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_seen != hold_toggle) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            pop       <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            pop      <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(0, 4);
            pop      <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_words
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (pending_words.size() == 0) begin
                if (bad_words < 10) begin
                    $display("%0t unexpected result word: pix=%0d ra=%b dec=%b col=%0d row=%0d",
                             $time, o_res_word.pixel_value, o_res_word.ra_moving,
                             o_res_word.dec_moving, o_res_word.star_col, o_res_word.star_row);
                end
                bad_words = bad_words + 1;
            end else begin
                want = pending_words.pop_front();
                if (o_res_word.pixel_value !== want.pixel_value ||
                    o_res_word.ra_moving !== want.ra_moving ||
                    o_res_word.dec_moving !== want.dec_moving ||
                    o_res_word.star_col !== want.star_col ||
                    o_res_word.star_row !== want.star_row) begin
                    if (bad_words < 10) begin
                        $display("%0t word mismatch: expected pix=%0d ra=%b dec=%b col=%0d row=%0d",
                                 $time, want.pixel_value, want.ra_moving, want.dec_moving,
                                 want.star_col, want.star_row);
                        $display("%0t                actual pix=%0d ra=%b dec=%b col=%0d row=%0d",
                                 $time, o_res_word.pixel_value, o_res_word.ra_moving,
                                 o_res_word.dec_moving, o_res_word.star_col, o_res_word.star_row);
                    end
                    bad_words = bad_words + 1;
                end
            end
        end
    end

    initial begin : main_sequence
        logic [63:0] e;
        e = 64'd1 << 32;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            exp_table[k] = e[32:16];
            e = (e * EXP_RATIO + (64'd1 << 31)) >> 32;
        end
        cam_cfg.drift_rate_x = 24'd1678;
        cam_cfg.drift_rate_y = 24'd3355;
        cam_cfg.guide_rate   = 24'd167772;
        cam_cfg.axis_cos     = 16'd17705;
        cam_cfg.axis_sin     = 16'd27574;
        cam_cfg.peak_level   = 16'd10000;
        star_x   = 40'sd320 <<< 24;
        star_y   = 40'sd240 <<< 24;
        ra_left  = '0;
        dec_left = '0;
        ra_neg   = 1'b0;
        dec_neg  = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_register_settings();
        test_backpressure();
        test_quiet_stream();
        test_position_limits();

        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (bad_words == 0 && pending_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
